// ===== rtl/beacon_signal_qualifier_assert.svh =====
// Assertion macros for the beacon signal qualifier RTL.
`ifndef BEACON_SIGNAL_QUALIFIER_ASSERT_SVH
`define BEACON_SIGNAL_QUALIFIER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is low.
`define BSQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("beacon_signal_qualifier assertion failed");
// Clocked check that also holds while reset is low.
`define BSQ_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("beacon_signal_qualifier assertion failed");
`else
`define BSQ_ASSERT(name, prop)
`define BSQ_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== rtl/bsq_pkg.sv =====
// Types, constants and helpers shared by the beacon signal qualifier.
package bsq_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned NumChannels      = 10;
  localparam int unsigned NumFlags         = 8;
  localparam int unsigned InDataWidth      = 48;
  localparam int unsigned OutDataWidth     = 16;
  localparam logic [31:0] HoldTimeReset    = 32'd100;

  // Channel numbers
  localparam int unsigned ChNear    = 0;
  localparam int unsigned ChFar     = 1;
  localparam int unsigned ChChassis = 2;
  localparam int unsigned ChMarker  = 3;
  localparam int unsigned ChCode1   = 4;
  localparam int unsigned ChCode2   = 5;
  localparam int unsigned ChAuto    = 6;
  localparam int unsigned ChDnSecond = 8;
  localparam int unsigned ChDnThird  = 9;
  localparam int unsigned FlagDayNight = 7;

  // Configuration register indexes
  localparam logic CfgBoardType = 1'b0;
  localparam logic CfgHoldTime  = 1'b1;

  typedef enum logic [1:0] {
    BOARD_FIRST  = 2'd0,
    BOARD_SECOND = 2'd1,
    BOARD_THIRD  = 2'd2,
    BOARD_NONE   = 2'd3
  } board_e;

  typedef struct packed {
    logic       select_far;
    logic       lamp_on;
    logic       marker_latched;
    logic       day_night;
    logic       auto_mode_on;
    logic [1:0] panel_id;
    logic       marker_on;
    logic       chassis_on;
    logic       far_on;
    logic       near_on;
  } result_t;

  // Channels that a board type qualifies.
  function automatic logic [NumChannels-1:0] chan_enable(board_e board);
    logic [NumChannels-1:0] en;
    en = '0;
    unique case (board)
      BOARD_FIRST: begin
        en[ChNear] = 1'b1; en[ChFar] = 1'b1; en[ChChassis] = 1'b1;
        en[ChMarker] = 1'b1; en[ChCode1] = 1'b1; en[ChCode2] = 1'b1;
        en[ChAuto] = 1'b1;
      end
      BOARD_SECOND: begin
        en[ChNear] = 1'b1; en[ChFar] = 1'b1; en[ChChassis] = 1'b1;
        en[ChMarker] = 1'b1; en[ChAuto] = 1'b1; en[ChDnSecond] = 1'b1;
      end
      BOARD_THIRD: en[ChDnThird] = 1'b1;
      BOARD_NONE:  en = '0;
      default:     en = '0;
    endcase
    return en;
  endfunction

endpackage

// ===== rtl/beacon_signal_qualifier.sv =====
// Beacon signal qualifier: debounced beacon panel channels and near/far selection.
//
// Usage:
//  - Slave stream (s_axis_*): one poll per transaction, ten raw pin levels plus
//    a free-running 32-bit tick stamp. Each poll gives exactly one result.
//  - Master stream (m_axis_*): qualified flags, marker latch, lamp level and
//    the near/far beacon select for that poll.
//  - Config channel (cfg_*): index 0 board_type, index 1 hold_time. Always
//    ready; write only while no poll is in flight.
//  - Timing: a poll sits in the input register while the qualify and select
//    logic runs on it, and the result register loads from that logic once
//    the output is free. One poll per cycle is sustained while m_axis_tready
//    stays high; the per-channel stamp subtract and compare (ten in
//    parallel) plus the select logic is the path that sets the cycle.
//  - Stall: while the result register is held by m_axis_tready low, the
//    input register still accepts one more poll, then s_axis_tready drops.
//  - Reset: all stamps, flags, marker latch and lamp clear; board_type goes
//    to the first type and hold_time to 100 ticks.
module beacon_signal_qualifier
  import bsq_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // tdata: [9:0] raw_pins, [41:10] now_time, [47:42] zero
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // tdata: [0] near_on, [1] far_on, [2] chassis_on, [3] marker_on,
  // [5:4] panel_id, [6] auto_mode_on, [7] day_night, [8] marker_latched,
  // [9] lamp_on, [10] select_far, [15:11] zero
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  `include "beacon_signal_qualifier_assert.svh"

  // Compare width covers both the elapsed time and the 32-bit hold time
  localparam int unsigned CmpWidth = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  // Config registers
  board_e      board_q;
  logic [31:0] hold_q;

  // Input register
  logic                   in_vld_q;
  logic [NumChannels-1:0] in_pins_q;
  logic [31:0]            in_now_q;

  // State
  logic [TIME_WIDTH-1:0] on_stamp_q  [NumChannels];
  logic [TIME_WIDTH-1:0] off_stamp_q [NumChannels];
  logic [NumFlags-1:0]   flags_q, flags_d;
  logic                  mhold_q, mhold_d;
  logic                  lamp_q, lamp_d;
  logic                  sel_far;

  // Result register
  logic    out_vld_q;
  result_t res_q, res_d;

  logic                   fire;
  logic [TIME_WIDTH-1:0]  now_w;
  logic [NumChannels-1:0] chan_en;
  logic [NumChannels-1:0] asserted;
  logic [NumChannels-1:0] turn_on;
  logic [NumChannels-1:0] turn_off;

  // Handshakes
  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataWidth'(res_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q <= BOARD_FIRST;
      hold_q  <= HoldTimeReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgBoardType: board_q <= board_e'(cfg_data_i[1:0]);
        CfgHoldTime:  hold_q  <= cfg_data_i;
        default:      hold_q  <= hold_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pins_q <= s_axis_tdata[NumChannels-1:0];
      in_now_q  <= s_axis_tdata[NumChannels +: 32];
    end
  end

  // Per-channel qualification, all channels in parallel
  assign now_w   = TIME_WIDTH'(in_now_q);
  assign chan_en = chan_enable(board_q);

  always_comb begin
    logic [TIME_WIDTH-1:0] el_on;
    logic [TIME_WIDTH-1:0] el_off;
    for (int c = 0; c < NumChannels; c++) begin
      el_on  = now_w - on_stamp_q[c];
      el_off = now_w - off_stamp_q[c];
      // marker is active high, all others active low
      asserted[c] = (c == ChMarker) ? in_pins_q[c] : !in_pins_q[c];
      turn_on[c]  = chan_en[c] && asserted[c] &&
                    (CmpWidth'(el_on) > CmpWidth'(hold_q));
      turn_off[c] = chan_en[c] && !asserted[c] &&
                    (CmpWidth'(el_off) > CmpWidth'(hold_q));
    end
  end

  always_comb begin
    flags_d = flags_q;
    for (int c = 0; c < FlagDayNight; c++) begin
      if (turn_on[c]) begin
        flags_d[c] = 1'b1;
      end else if (turn_off[c]) begin
        flags_d[c] = 1'b0;
      end
    end
    // day/night comes from channel 8 or 9; boards never enable both
    if (turn_on[ChDnSecond] || turn_on[ChDnThird]) begin
      flags_d[FlagDayNight] = 1'b1;
    end else if (turn_off[ChDnSecond] || turn_off[ChDnThird]) begin
      flags_d[FlagDayNight] = 1'b0;
    end
  end

  // Near/far selection on the freshly qualified flags
  always_comb begin
    mhold_d = mhold_q;
    lamp_d  = lamp_q;
    sel_far = 1'b1;
    unique case (board_q)
      BOARD_FIRST: begin
        if (flags_d[ChChassis]) begin
          mhold_d = 1'b0;
        end
        priority if (flags_d[ChFar]) begin
          lamp_d  = 1'b0;
          sel_far = 1'b1;
        end else if (flags_d[ChNear]) begin
          lamp_d  = 1'b1;
          sel_far = 1'b0;
        end else if (flags_d[ChChassis]) begin
          lamp_d  = 1'b0;
          sel_far = 1'b1;
        end else if (flags_d[ChMarker]) begin
          mhold_d = 1'b1;
          lamp_d  = 1'b1;
          sel_far = 1'b0;
        end else if (mhold_q && flags_d[ChAuto]) begin
          // latched marker keeps near while in automatic mode
          lamp_d  = 1'b1;
          sel_far = 1'b0;
        end else begin
          mhold_d = 1'b0;
          lamp_d  = 1'b0;
          sel_far = 1'b1;
        end
      end
      BOARD_THIRD: sel_far = !flags_d[ChNear];
      BOARD_SECOND, BOARD_NONE: sel_far = 1'b1;
      default: sel_far = 1'b1;
    endcase
  end

  always_comb begin
    res_d.near_on        = flags_d[ChNear];
    res_d.far_on         = flags_d[ChFar];
    res_d.chassis_on     = flags_d[ChChassis];
    res_d.marker_on      = flags_d[ChMarker];
    res_d.panel_id       = {flags_d[ChCode2], flags_d[ChCode1]};
    res_d.auto_mode_on   = flags_d[ChAuto];
    res_d.day_night      = flags_d[FlagDayNight];
    res_d.marker_latched = mhold_d;
    res_d.lamp_on        = lamp_d;
    res_d.select_far     = sel_far;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      mhold_q <= 1'b0;
      lamp_q  <= 1'b0;
      for (int c = 0; c < NumChannels; c++) begin
        on_stamp_q[c]  <= '0;
        off_stamp_q[c] <= '0;
      end
    end else if (fire) begin
      flags_q <= flags_d;
      mhold_q <= mhold_d;
      lamp_q  <= lamp_d;
      for (int c = 0; c < NumChannels; c++) begin
        if (turn_on[c]) begin
          off_stamp_q[c] <= now_w;
        end
        if (turn_off[c]) begin
          on_stamp_q[c] <= now_w;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Checks
  `BSQ_ASSERT(a_ready_only_blocks_when_full, !s_axis_tready |-> in_vld_q && out_vld_q)
  `BSQ_ASSERT(a_fire_loads_result, fire |=> out_vld_q)
  `BSQ_ASSERT(a_no_latch_change_off_first,
    fire && board_q != BOARD_FIRST |=> $stable(mhold_q) && $stable(lamp_q))
  `BSQ_ASSERT(a_none_keeps_flags, fire && board_q == BOARD_NONE |=> $stable(flags_q))
  `BSQ_ASSERT(a_far_flag_selects_far,
    fire && board_q == BOARD_FIRST && flags_d[ChFar] |=> res_q.select_far && !lamp_q)
  `BSQ_ASSERT_ALWAYS(a_reset_clears_output, !rst_ni |=> !m_axis_tvalid)

endmodule

// ===== sim/tb.sv =====
// Self-checking stream testbench for the beacon signal qualifier.
`timescale 1ns / 100ps

module tb;
  import bsq_pkg::*;

  localparam int CycleLimit = 400_000;
  localparam int RandPolls  = 1450;

  typedef enum logic {ROW_POLL, ROW_CFG} row_e;

  // One line of the directed table. A config line writes both registers.
  typedef struct {
    row_e        kind;
    board_e      brd;
    logic [31:0] hold;
    logic [9:0]  pins;
    logic [31:0] stamp;
    bit          chk;    // want is typed in by hand
    result_t     want;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic                    cfg_index_i = 1'b0;
  logic [31:0]             cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  beacon_signal_qualifier i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // ---------------------------------------------------------------------------
  // Directed table. Expected values are typed in only where obvious: the
  // first poll after reset (nothing has had time to qualify) and the first
  // full-assert poll just past the default hold time.
  // ---------------------------------------------------------------------------
  dir_row_t dir_table [25] = '{
    // after reset, board first / hold 100: nothing qualifies yet
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3FF, 32'd0,          1'b1, 11'h400},
    // all low-active channels asserted, one tick past the hold time
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h000, 32'd101,        1'b1, 11'h477},
    // elapsed equals hold: no change allowed
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3FF, 32'd201,        1'b0, '0},
    // one past: flags drop, marker (high-active) comes on and latches
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3FF, 32'd202,        1'b0, '0},
    // marker gone, auto mode on: latched marker keeps near selected
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3B7, 32'd400,        1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3F7, 32'd401,        1'b0, '0},
    // zero hold time
    '{ROW_CFG,  BOARD_FIRST,  32'd0,          10'h000, 32'd0,          1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3FE, 32'd402,        1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3FB, 32'd402,        1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3FB, 32'd403,        1'b0, '0},
    // maximum hold time: no flag can ever move
    '{ROW_CFG,  BOARD_FIRST,  32'hFFFF_FFFF,  10'h000, 32'd0,          1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h000, 32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3FF, 32'd0,          1'b0, '0},
    // second type: day/night from channel 8, always far
    '{ROW_CFG,  BOARD_SECOND, 32'd0,          10'h000, 32'd0,          1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h0FF, 32'h7FFF_FFFF,  1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h2D5, 32'h8000_0000,  1'b0, '0},
    // third type: day/night from channel 9, far unless near is qualified
    '{ROW_CFG,  BOARD_THIRD,  32'd5,          10'h000, 32'd0,          1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h1FF, 32'h8000_0010,  1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h3FF, 32'h8000_0020,  1'b0, '0},
    // undefined board code: nothing qualifies, far selected
    '{ROW_CFG,  BOARD_NONE,   32'd0,          10'h000, 32'd0,          1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h000, 32'd0,          1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h155, 32'd1,          1'b0, '0},
    // back to first type, time stamp wraps through zero
    '{ROW_CFG,  BOARD_FIRST,  32'd100,        10'h000, 32'd0,          1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h000, 32'hFFFF_FFF0,  1'b0, '0},
    '{ROW_POLL, BOARD_FIRST,  32'd0,          10'h2AA, 32'h0000_0060,  1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Predictor state: per-channel stamps gating the next rise / fall, the
  // qualified flags, marker latch, lamp, and the current register values.
  // ---------------------------------------------------------------------------
  logic [31:0] rise_gate [NumChannels];  // time that a rise is measured from
  logic [31:0] fall_gate [NumChannels];  // time that a fall is measured from
  logic [NumFlags-1:0] qflags = '0;
  logic        marker_latch = 1'b0;
  logic        lamp_lvl = 1'b0;
  board_e      board = BOARD_FIRST;
  logic [31:0] hold_ticks = HoldTimeReset;

  result_t     pending_q [$];  // results still owed by the block

  int errors       = 0;
  int results_seen = 0;
  int polls_sent   = 0;
  int cfg_settings = 0;
  int cycles       = 0;

  // sender pacing
  int burst_left = 0;
  bit offering   = 1'b0;

  initial begin
    foreach (rise_gate[i]) begin
      rise_gate[i] = '0;
      fall_gate[i] = '0;
    end
  end

  // One channel through the hold-time filter into flag bit fb.
  function automatic void debounce(int unsigned ch, int unsigned fb, bit active,
                                   logic [31:0] now);
    if (active) begin
      if (now - rise_gate[ch] > hold_ticks) begin
        qflags[fb]    = 1'b1;
        fall_gate[ch] = now;
      end
    end else if (now - fall_gate[ch] > hold_ticks) begin
      qflags[fb]    = 1'b0;
      rise_gate[ch] = now;
    end
  endfunction

  // Full prediction for one poll; updates the predictor state.
  function automatic result_t qualify_poll(logic [9:0] pins, logic [31:0] now);
    result_t r;
    logic    far_sel;
    far_sel = 1'b1;
    case (board)
      BOARD_FIRST: begin
        debounce(ChNear,    ChNear,    !pins[ChNear],    now);
        debounce(ChFar,     ChFar,     !pins[ChFar],     now);
        debounce(ChChassis, ChChassis, !pins[ChChassis], now);
        debounce(ChMarker,  ChMarker,  pins[ChMarker],   now);
        debounce(ChCode1,   ChCode1,   !pins[ChCode1],   now);
        debounce(ChCode2,   ChCode2,   !pins[ChCode2],   now);
        debounce(ChAuto,    ChAuto,    !pins[ChAuto],    now);
        // beacon selection: far wins, then near, then chassis, then marker / latched marker
        if (qflags[ChChassis]) marker_latch = 1'b0;
        if (qflags[ChFar]) begin
          lamp_lvl = 1'b0;
          far_sel  = 1'b1;
        end else if (qflags[ChNear]) begin
          lamp_lvl = 1'b1;
          far_sel  = 1'b0;
        end else if (!qflags[ChChassis] && qflags[ChMarker]) begin
          marker_latch = 1'b1;
          lamp_lvl     = 1'b1;
          far_sel      = 1'b0;
        end else if (!qflags[ChChassis] && marker_latch && qflags[ChAuto]) begin
          lamp_lvl = 1'b1;
          far_sel  = 1'b0;
        end else begin
          marker_latch = 1'b0;
          lamp_lvl     = 1'b0;
          far_sel      = 1'b1;
        end
      end
      BOARD_SECOND: begin
        debounce(ChNear,     ChNear,       !pins[ChNear],     now);
        debounce(ChFar,      ChFar,        !pins[ChFar],      now);
        debounce(ChChassis,  ChChassis,    !pins[ChChassis],  now);
        debounce(ChMarker,   ChMarker,     pins[ChMarker],    now);
        debounce(ChAuto,     ChAuto,       !pins[ChAuto],     now);
        debounce(ChDnSecond, FlagDayNight, !pins[ChDnSecond], now);
      end
      BOARD_THIRD: begin
        debounce(ChDnThird, FlagDayNight, !pins[ChDnThird], now);
        far_sel = !qflags[ChNear];
      end
      default: far_sel = 1'b1;
    endcase
    r.near_on        = qflags[ChNear];
    r.far_on         = qflags[ChFar];
    r.chassis_on     = qflags[ChChassis];
    r.marker_on      = qflags[ChMarker];
    r.panel_id       = {qflags[ChCode2], qflags[ChCode1]};
    r.auto_mode_on   = qflags[ChAuto];
    r.day_night      = qflags[FlagDayNight];
    r.marker_latched = marker_latch;
    r.lamp_on        = lamp_lvl;
    r.select_far     = far_sel;
    return r;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf({"near=%0b far=%0b chassis=%0b marker=%0b panel=%0d auto=%0b ",
                      "dn=%0b latch=%0b lamp=%0b sel_far=%0b"},
                     r.near_on, r.far_on, r.chassis_on, r.marker_on, r.panel_id,
                     r.auto_mode_on, r.day_night, r.marker_latched, r.lamp_on,
                     r.select_far);
  endfunction

  // Offer one poll; bursts of random length with random gaps in between.
  // Returns right after the accepting edge with tvalid still high.
  task automatic send_poll(input logic [9:0] pins, input logic [31:0] stamp,
                           input bit chk, input result_t want);
    result_t pred;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      if (offering) s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataWidth - 42){1'b0}}, stamp, pins};
    offering = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    polls_sent++;
    pred = qualify_poll(pins, stamp);
    pending_q.push_back(chk ? want : pred);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain();
    if (offering) s_axis_tvalid <= 1'b0;
    offering   = 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back; only called with the block idle.
  task automatic set_config(input board_e brd, input logic [31:0] hold);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgBoardType;
    cfg_data_i  <= {30'd0, brd};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board = brd;
    cfg_index_i <= CfgHoldTime;
    cfg_data_i  <= hold;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    hold_ticks = hold;
    cfg_valid_i <= 1'b0;
    cfg_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every accepted transaction against the oldest owed
  // result, and drive tready. The stall rate is redrawn at regular intervals; a
  // long hold-off kicks in a few times so the input side backs up.
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int pace_left = 0;
  int hold_off  = 0;

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %s", fmt_result(got));
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d mismatch\n  exp %s\n  got %s",
                     results_seen, fmt_result(want), fmt_result(got));
        end
      end
      if (results_seen % 500 == 250) hold_off = 120;
    end
    if (pace_left == 0) begin
      pace_left = 150;
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 25;
        3:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    pace_left--;
    if (hold_off != 0) begin
      hold_off--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ERROR: timeout after %0d cycles, %0d results owed", cycles,
               pending_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          phase;
    int          n_items;
    int          rand_polls;
    int          dir_polls;
    board_e      brd;
    logic [31:0] hl;
    logic [31:0] tick;
    logic [9:0]  pin_lvl;

    rand_polls = 0;
    phase      = 0;
    tick       = '0;
    pin_lvl    = '1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain();
        set_config(dir_table[i].brd, dir_table[i].hold);
      end else begin
        send_poll(dir_table[i].pins, dir_table[i].stamp, dir_table[i].chk,
                  dir_table[i].want);
      end
    end
    dir_polls = polls_sent;

    // random part: phases of register settings, pins drifting a few bits at
    // a time so flags actually get to qualify, time stepping near hold_time
    while (rand_polls < RandPolls) begin
      case (phase)
        0:       begin brd = BOARD_FIRST;  hl = HoldTimeReset;            end
        1:       begin brd = BOARD_FIRST;  hl = 32'd0;                    end
        2:       begin brd = BOARD_SECOND; hl = $urandom_range(1, 16);    end
        3:       begin brd = BOARD_THIRD;  hl = $urandom_range(1, 16);    end
        4:       begin brd = BOARD_FIRST;  hl = 32'hFFFF_FFFF;            end
        5:       begin brd = BOARD_NONE;   hl = 32'd3;                    end
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: brd = BOARD_FIRST;
            6, 7:             brd = BOARD_SECOND;
            8:                brd = BOARD_THIRD;
            default:          brd = BOARD_NONE;
          endcase
          case ($urandom_range(0, 9))
            0:          hl = 32'd0;
            1, 2, 3, 4: hl = $urandom_range(1, 16);
            5, 6, 7:    hl = $urandom_range(17, 300);
            8:          hl = 32'hFFFF_FFFF;
            default:    hl = $urandom;
          endcase
        end
      endcase
      drain();
      set_config(brd, hl);

      n_items = (hl > 32'd300 || brd == BOARD_NONE) ? $urandom_range(20, 40)
                                                   : $urandom_range(80, 160);
      if ($urandom_range(0, 2) == 0) tick = 32'hFFFF_FFFF - $urandom_range(0, 600);

      for (int k = 0; k < n_items; k++) begin
        // in phase 2 the sender waits for the block to empty once, mid-phase
        if (phase == 2 && k == n_items / 2) drain();
        if ($urandom_range(0, 39) == 0) tick = $urandom;
        else if (hl > 32'd300)          tick += $urandom;
        else                            tick += $urandom_range(0, 2 * hl + 2);
        if ($urandom_range(0, 19) == 0) pin_lvl = $urandom;
        else                            pin_lvl ^= 10'($urandom & $urandom & $urandom);
        send_poll(pin_lvl, tick, 1'b0, '0);
        rand_polls++;
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      errors += pending_q.size();
      $display("ERROR: %0d results never arrived", pending_q.size());
    end

    $display("Covered %0d polls (%0d from the directed table) over %0d register settings,",
             polls_sent, dir_polls, cfg_settings);
    $display("all board codes, hold 0 to max, stamp wrap; %0d results, %0d errors.",
             results_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
